// File: sv/ifft_pkg.sv
// ----------------------------------------------------------------------------
// ifft_pkg
// shared types and constants of the ip fragment flow tracker
// ----------------------------------------------------------------------------
package ifft_pkg;

    localparam int TableDepthDefault = 128;
    localparam logic [39:0] ExpiryReset = 40'd30_000_000;

    localparam logic [1:0] ST_STORED    = 2'd0;
    localparam logic [1:0] ST_KEPT      = 2'd1;
    localparam logic [1:0] ST_FREED     = 2'd2;
    localparam logic [1:0] ST_REJECTED  = 2'd3;

    // one table entry as it travels along the chain
    typedef struct packed {
        logic        valid;
        logic [31:0] frag_id;
        logic        is_ipv6;
        logic [63:0] src_hi;
        logic [63:0] src_lo;
        logic [63:0] dst_hi;
        logic [63:0] dst_lo;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [63:0] time_us;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_PLACE,
        S_DONE
    } t_state;

endpackage

// File: sv/ifft_cell.sv
// ----------------------------------------------------------------------------
// ifft_cell
// one table entry of the rotating chain
// ----------------------------------------------------------------------------
module ifft_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_shift,
    input  ifft_pkg::t_entry  i_entry,
    output ifft_pkg::t_entry  o_entry
);

    logic            r_valid;
    ifft_pkg::t_entry r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_entry.valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_entry;
        end
    end

    always_comb begin
        o_entry       = r_data;
        o_entry.valid = r_valid;
    end

endmodule

// File: sv/ip_fragment_flow_tracker_unit.sv
// ----------------------------------------------------------------------------
// ip_fragment_flow_tracker_unit
// fragment reassembly tracking table built as a rotating chain of entries
// ----------------------------------------------------------------------------
// The table is a ring of TABLE_DEPTH cells that rotates by one entry per
// cycle while a fragment is searched or placed; the controller looks at the
// head cell and writes it back, possibly changed, into the tail. A fragment
// takes one full rotation to search for a matching entry (freeing it on the
// last fragment), and when nothing matched a second rotation to clear expired
// entries (only if the table is full) and drop the new entry into the lowest
// free slot. Both rotations pass every entry through the single compare unit
// at the head of the ring. The result sits in an output register, so the
// next fragment can be taken while it waits. The expiry register may be
// written at any time the block is idle.
// ----------------------------------------------------------------------------
module ip_fragment_flow_tracker_unit #(
    parameter int TABLE_DEPTH = ifft_pkg::TableDepthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // fragment channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_frag_id,
    input  logic        i_is_ipv6,
    input  logic [63:0] i_src_addr_hi,
    input  logic [63:0] i_src_addr_lo,
    input  logic [63:0] i_dst_addr_hi,
    input  logic [63:0] i_dst_addr_lo,
    input  logic [15:0] i_src_port,
    input  logic [15:0] i_dst_port,
    input  logic        i_more_fragments,
    input  logic [63:0] i_time_us,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_src_port_out,
    output logic [15:0] o_dst_port_out,
    output logic [7:0]  o_cleared_count,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [39:0] i_cfg_expiry_time_us
);

    localparam int CW = $clog2(TABLE_DEPTH);
    localparam int OW = $clog2(TABLE_DEPTH + 1);

    ifft_pkg::t_state r_state, n_state;

    logic [39:0]      r_expiry;
    ifft_pkg::t_entry r_frag;        // fragment under work, ipv4 halves zeroed
    logic             r_more;
    logic [CW-1:0]    r_cnt;
    logic [OW-1:0]    r_occ, n_occ;
    logic             r_hit, n_hit;
    logic             r_full;
    logic             r_ins, n_ins;
    logic [7:0]       r_cleared, n_cleared;
    logic [15:0]      r_hit_sport, r_hit_dport;

    logic             r_out_valid;
    logic [1:0]       r_status;
    logic [15:0]      r_sport_o, r_dport_o;
    logic [7:0]       r_cleared_o;

    ifft_pkg::t_entry w_chain [TABLE_DEPTH];
    ifft_pkg::t_entry w_head, w_ret;
    logic             w_shift;
    logic             w_last;
    logic             w_match;
    logic [63:0]      w_age;
    logic             w_expired;
    logic             w_free;
    logic             w_load_out;

    // ring of cells, entry i moves to i-1, head feeds back into the tail
    assign w_shift = (r_state == ifft_pkg::S_SEARCH) || (r_state == ifft_pkg::S_PLACE);
    assign w_head  = w_chain[0];

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        ifft_pkg::t_entry w_in;
        if (g == TABLE_DEPTH - 1) begin : g_tail
            assign w_in = w_ret;
        end else begin : g_mid
            assign w_in = w_chain[g+1];
        end
        ifft_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_entry (w_in),
            .o_entry (w_chain[g])
        );
    end

    assign w_last = (r_cnt == CW'(TABLE_DEPTH - 1));

    // match on id and family, address pair in either order
    assign w_match = w_head.valid && (w_head.frag_id == r_frag.frag_id) &&
                     (w_head.is_ipv6 == r_frag.is_ipv6) &&
                     (((w_head.src_hi == r_frag.src_hi) && (w_head.src_lo == r_frag.src_lo) &&
                       (w_head.dst_hi == r_frag.dst_hi) && (w_head.dst_lo == r_frag.dst_lo)) ||
                      ((w_head.src_hi == r_frag.dst_hi) && (w_head.src_lo == r_frag.dst_lo) &&
                       (w_head.dst_hi == r_frag.src_hi) && (w_head.dst_lo == r_frag.src_lo)));

    // wrapping age against the 40-bit expiry time
    assign w_age     = r_frag.time_us - w_head.time_us;
    assign w_expired = r_full && w_head.valid &&
                       ((w_age[63:40] != 24'd0) || (w_age[39:0] > r_expiry));
    assign w_free    = !w_head.valid || w_expired;

    // head write-back and per-transaction bookkeeping
    always_comb begin
        w_ret     = w_head;
        n_hit     = r_hit;
        n_ins     = r_ins;
        n_occ     = r_occ;
        n_cleared = r_cleared;
        if (r_state == ifft_pkg::S_IDLE) begin
            // fresh bookkeeping for the next transaction
            n_hit     = 1'b0;
            n_ins     = 1'b0;
            n_cleared = '0;
        end else if (r_state == ifft_pkg::S_SEARCH) begin
            if (w_match && !r_hit) begin
                n_hit = 1'b1;
                if (!r_more) begin
                    w_ret.valid = 1'b0;
                    n_occ       = r_occ - OW'(1);
                end
            end
        end else if (r_state == ifft_pkg::S_PLACE) begin
            if (w_expired) begin
                w_ret.valid = 1'b0;
                n_occ       = n_occ - OW'(1);
                if (r_cleared != 8'hff) begin
                    n_cleared = r_cleared + 8'd1;
                end
            end
            if (w_free && !r_ins) begin
                w_ret = r_frag;
                n_ins = 1'b1;
                n_occ = n_occ + OW'(1);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ifft_pkg::S_IDLE: begin
                if (i_in_valid) n_state = ifft_pkg::S_SEARCH;
            end
            ifft_pkg::S_SEARCH: begin
                if (w_last) n_state = n_hit ? ifft_pkg::S_DONE : ifft_pkg::S_PLACE;
            end
            ifft_pkg::S_PLACE: begin
                if (w_last) n_state = ifft_pkg::S_DONE;
            end
            ifft_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) n_state = ifft_pkg::S_IDLE;
            end
            default: n_state = ifft_pkg::S_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        o_in_ready = 1'b0;
        w_load_out = 1'b0;
        unique case (r_state)
            ifft_pkg::S_IDLE: o_in_ready = 1'b1;
            ifft_pkg::S_DONE: w_load_out = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ifft_pkg::S_IDLE;
            r_expiry    <= ifft_pkg::ExpiryReset;
            r_occ       <= '0;
            r_cnt       <= '0;
            r_hit       <= 1'b0;
            r_ins       <= 1'b0;
            r_full      <= 1'b0;
            r_cleared   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) r_expiry <= i_cfg_expiry_time_us;
            r_occ     <= n_occ;
            r_hit     <= n_hit;
            r_ins     <= n_ins;
            r_cleared <= n_cleared;
            if (w_shift) begin
                r_cnt <= w_last ? '0 : r_cnt + CW'(1);
            end else if (r_state == ifft_pkg::S_IDLE) begin
                r_cnt <= '0;
            end
            if (r_state == ifft_pkg::S_SEARCH && w_last) begin
                r_full <= (r_occ >= OW'(TABLE_DEPTH));
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // fragment capture and result payload
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_frag.valid    <= 1'b1;
            r_frag.frag_id  <= i_frag_id;
            r_frag.is_ipv6  <= i_is_ipv6;
            r_frag.src_hi   <= i_is_ipv6 ? i_src_addr_hi : 64'd0;
            r_frag.src_lo   <= i_is_ipv6 ? i_src_addr_lo : {32'd0, i_src_addr_lo[31:0]};
            r_frag.dst_hi   <= i_is_ipv6 ? i_dst_addr_hi : 64'd0;
            r_frag.dst_lo   <= i_is_ipv6 ? i_dst_addr_lo : {32'd0, i_dst_addr_lo[31:0]};
            r_frag.src_port <= i_src_port;
            r_frag.dst_port <= i_dst_port;
            r_frag.time_us  <= i_time_us;
            r_more          <= i_more_fragments;
        end
        if (r_state == ifft_pkg::S_SEARCH && w_match && !r_hit) begin
            r_hit_sport <= w_head.src_port;
            r_hit_dport <= w_head.dst_port;
        end
        if (w_load_out) begin
            if (r_hit) begin
                r_status    <= r_more ? ifft_pkg::ST_KEPT : ifft_pkg::ST_FREED;
                r_sport_o   <= r_hit_sport;
                r_dport_o   <= r_hit_dport;
                r_cleared_o <= 8'd0;
            end else begin
                r_status    <= r_ins ? ifft_pkg::ST_STORED : ifft_pkg::ST_REJECTED;
                r_sport_o   <= r_frag.src_port;
                r_dport_o   <= r_frag.dst_port;
                r_cleared_o <= r_cleared;
            end
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_src_port_out  = r_sport_o;
    assign o_dst_port_out  = r_dport_o;
    assign o_cleared_count = r_cleared_o;

endmodule

// File: sv/ifft_checker.sv
// ----------------------------------------------------------------------------
// ifft_checker
// port level checks of the fragment tracker
// ----------------------------------------------------------------------------
module ifft_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_status,
    input logic [7:0]  o_cleared_count
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status))
        else $error("result dropped while stalled");

    // a match never clears entries
    a_match_no_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ifft_pkg::ST_KEPT || o_status == ifft_pkg::ST_FREED)
        |-> o_cleared_count == 8'd0)
        else $error("cleared count on a match");

    // a reject means nothing expired
    a_reject_no_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ifft_pkg::ST_REJECTED |-> o_cleared_count == 8'd0)
        else $error("reject with cleared entries");

    // an accepted fragment keeps the block busy at the start of the search
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready ##1 !o_in_ready)
        else $error("input taken during search");

endmodule

bind ip_fragment_flow_tracker_unit ifft_checker u_ifft_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_status        (o_status),
    .o_cleared_count (o_cleared_count)
);
